// ===== hw/rtl/huffman_tree_decoder_top_macros.svh =====
// Assertion macros used by the decoder checker.
`ifndef HUFFMAN_TREE_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_DECODER_TOP_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define HTD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define HTD_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== hw/rtl/htd_pkg.sv =====
// Shared constants, codes and helpers of the Huffman tree decoder.
package htd_pkg;

    localparam int SYM_W            = 8;
    localparam int LEN_W            = 6;
    localparam int BITS_W           = 32;
    localparam int BYTE_W           = 8;
    localparam int STAT_W           = 3;
    localparam int CNT_W            = 32;
    localparam int DEF_NODE_DEPTH   = 512;
    localparam int MAX_CODE_LEN     = 32;

    localparam int S_TDATA_W        = 56;
    localparam int M_TDATA_W        = 16;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic OP_LOAD        = 1'b0;
    localparam logic OP_DATA        = 1'b1;

    localparam logic REG_SYMBOL_COUNT = 1'b0;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LEN   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISSING   = 3'd3;
    localparam logic [STAT_W-1:0] ST_AFTER_END = 3'd4;

    // Code bit j of a len-bit code, first bit in position len-1; positions
    // above the code word read as zero.
    function automatic logic code_bit(input logic [BITS_W-1:0] bits,
                                      input logic [LEN_W-1:0]  len,
                                      input logic [LEN_W:0]    j);
        logic [LEN_W:0] pos;
        pos = {1'b0, len} - 7'd1 - j;
        return (pos < 7'd32) ? bits[pos[4:0]] : 1'b0;
    endfunction

endpackage

// ===== hw/rtl/htd_node_ram.sv =====
// Node memory: one write port, one read port with registered read data.
module htd_node_ram
    import htd_pkg::*;
#(
    parameter int DEPTH = DEF_NODE_DEPTH,
    parameter int WIDTH = 2 * $clog2(DEF_NODE_DEPTH) + SYM_W
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/htd_apb_regs.sv =====
// Configuration register file: symbol count behind an APB-style port.
module htd_apb_regs
    import htd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CNT_W-1:0]   o_symbol_count
);

    logic [CNT_W-1:0] r_count;
    logic             reg_idx;

    assign reg_idx = paddr[PADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (psel && penable && pwrite && (reg_idx == REG_SYMBOL_COUNT)) begin
            r_count <= pwdata;
        end
    end

    assign prdata         = (reg_idx == REG_SYMBOL_COUNT) ? r_count : '0;
    assign pready         = 1'b1;
    assign o_symbol_count = r_count;

endmodule

// ===== hw/rtl/huffman_tree_decoder_top.sv =====
// Huffman tree decoder top level: tree build and bit walk over node memory.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tuser: operation; tdata: code entry, data byte
//  m_axis    out  tvalid/tready, tlast    tuser: has_symbol; tdata: symbol, done, status
//  apb       in   psel/penable/pwrite     symbol_count at byte address 0
//
// A data byte takes one node memory read per bit walked, then closes the item.
// A load takes one read per existing code bit, then one write to hook the first
// new node and one write per new node.
// The walk issues one dependent node memory read per bit.
// Reset (synchronous, active low) clears the tree count, the walk position and
// the symbol counter; node memory holds no reset value and is only read where
// written. The block takes one item at a time and halts while m_axis stalls.
module huffman_tree_decoder_top
    import htd_pkg::*;
#(
    parameter int NODE_DEPTH = DEF_NODE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] code_symbol, [13:8] code_length, [45:14] code_bits,
    // [53:46] data_byte, [55:54] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] symbol, [8] stream_done, [11:9] status, [15:12] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] has_symbol
    output logic [0:0]           m_axis_tuser,
    output logic                 m_axis_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int AW   = $clog2(NODE_DEPTH);
    localparam int CW   = $clog2(NODE_DEPTH + 1);
    localparam int NW   = 2 * AW + SYM_W;
    localparam int SUMW = CW + 7;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_LWALK, S_LFULL, S_LCUR, S_LNEW, S_LDONE,
        S_DWALK, S_MISS, S_END
    } t_state;

    t_state r_state, n_state;

    logic               r_op, n_op;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [BITS_W-1:0]  r_bits, n_bits;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic [CW-1:0]      r_nu, n_nu;
    logic [AW-1:0]      r_wpos, n_wpos;
    logic [CNT_W-1:0]   r_emitted, n_emitted;
    logic [AW-1:0]      r_cur, n_cur;
    logic [NW-1:0]      r_cdata, n_cdata;
    logic [LEN_W-1:0]   r_depth, n_depth;
    logic [CW-1:0]      r_idx, n_idx;
    logic [6:0]         r_need, n_need;
    logic [3:0]         r_left, n_left;
    logic               r_at_cur, n_at_cur;
    logic               r_pend, n_pend;
    logic [SYM_W-1:0]   r_pend_sym, n_pend_sym;
    logic               r_pend_done, n_pend_done;
    logic [NW-1:0]      r_root;
    logic               r_ovalid, n_ovalid;
    logic [SYM_W-1:0]   r_osym, n_osym;
    logic               r_ohas, n_ohas;
    logic               r_olast, n_olast;
    logic               r_odone, n_odone;
    logic [STAT_W-1:0]  r_ostat, n_ostat;

    logic [CNT_W-1:0]   symbol_count;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [NW-1:0]      wr_data, rd_data;

    logic               push, p_has, p_last, p_done;
    logic [SYM_W-1:0]   p_sym;
    logic [STAT_W-1:0]  p_stat;
    logic               out_free, accept;
    logic               finished, done_after;

    logic [AW-1:0]      rd_c0, rd_c1;
    logic [SYM_W-1:0]   rd_sym;
    logic               landed_leaf;
    logic [NW-1:0]      step_node;
    logic [2:0]         bidx;
    logic               dbit;
    logic [AW-1:0]      step_c;
    logic               step_miss;
    logic               lbit, lbit_n, ld_last;
    logic [AW-1:0]      ld_c, new_child;
    logic               bad_len;

    htd_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_symbol_count (symbol_count)
    );

    htd_node_ram #(
        .DEPTH (NODE_DEPTH),
        .WIDTH (NW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign finished      = (r_emitted >= symbol_count);
    assign done_after    = (({1'b0, r_emitted} + 33'd1) >= {1'b0, symbol_count});

    // Node word: {symbol, 1-child, 0-child}
    assign rd_c0  = rd_data[AW-1:0];
    assign rd_c1  = rd_data[2*AW-1:AW];
    assign rd_sym = rd_data[NW-1:2*AW];

    // After a leaf the walk restarts from the cached root word.
    assign landed_leaf = !r_at_cur && (rd_c0 == '0);
    assign step_node   = landed_leaf ? r_root : rd_data;
    assign bidx        = 3'(r_left - 4'd1);
    assign dbit        = r_byte[bidx];
    assign step_c      = dbit ? step_node[2*AW-1:AW] : step_node[AW-1:0];
    assign step_miss   = (step_node[AW-1:0] == '0) || (step_c == '0);

    assign lbit      = code_bit(r_bits, r_len, {1'b0, r_depth});
    assign lbit_n    = code_bit(r_bits, r_len, {1'b0, r_depth} + 7'd1);
    assign ld_c      = lbit ? rd_c1 : rd_c0;
    assign ld_last   = (({1'b0, r_depth} + 7'd1) == {1'b0, r_len});
    assign new_child = ld_last ? '0 : AW'(r_idx + CW'(1));
    assign bad_len   = (r_len == '0) || ({1'b0, r_len} > 7'(MAX_CODE_LEN));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sym       = r_sym;
        n_len       = r_len;
        n_bits      = r_bits;
        n_byte      = r_byte;
        n_nu        = r_nu;
        n_wpos      = r_wpos;
        n_emitted   = r_emitted;
        n_cur       = r_cur;
        n_cdata     = r_cdata;
        n_depth     = r_depth;
        n_idx       = r_idx;
        n_need      = r_need;
        n_left      = r_left;
        n_at_cur    = r_at_cur;
        n_pend      = r_pend;
        n_pend_sym  = r_pend_sym;
        n_pend_done = r_pend_done;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        push        = 1'b0;
        p_sym       = '0;
        p_has       = 1'b0;
        p_last      = 1'b1;
        p_done      = finished;
        p_stat      = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = s_axis_tuser[0];
                    n_sym   = s_axis_tdata[7:0];
                    n_len   = s_axis_tdata[13:8];
                    n_bits  = s_axis_tdata[45:14];
                    n_byte  = s_axis_tdata[53:46];
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_op == OP_LOAD) begin
                    if (bad_len) begin
                        push   = 1'b1;
                        p_stat = ST_BAD_LEN;
                        if (out_free) n_state = S_IDLE;
                    end else if (r_nu == '0) begin
                        // Empty tree: the root is new and takes this symbol.
                        n_cur   = '0;
                        n_cdata = {r_sym, {(2*AW){1'b0}}};
                        n_depth = '0;
                        n_idx   = CW'(1);
                        n_need  = {1'b0, r_len} + 7'd1;
                        n_state = S_LFULL;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_cur   = '0;
                        n_depth = '0;
                        n_state = S_LWALK;
                    end
                end else begin
                    if (finished) begin
                        push   = 1'b1;
                        p_stat = ST_AFTER_END;
                        if (out_free) n_state = S_IDLE;
                    end else if (r_nu == '0) begin
                        push   = 1'b1;
                        p_stat = ST_MISSING;
                        if (out_free) n_state = S_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = r_wpos;
                        n_at_cur = 1'b1;
                        n_left   = 4'd8;
                        n_state  = S_DWALK;
                    end
                end
            end
            S_LWALK: begin
                if (r_depth == r_len) begin
                    // Whole path exists already: nothing to add.
                    push = 1'b1;
                    if (out_free) n_state = S_IDLE;
                end else if (ld_c == '0) begin
                    n_cdata = rd_data;
                    n_idx   = r_nu;
                    n_need  = {1'b0, r_len} - {1'b0, r_depth};
                    n_state = S_LFULL;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ld_c;
                    n_cur   = ld_c;
                    n_depth = r_depth + 6'd1;
                end
            end
            S_LFULL: begin
                if ((SUMW'(r_nu) + SUMW'(r_need)) > SUMW'(NODE_DEPTH)) begin
                    push   = 1'b1;
                    p_stat = ST_FULL;
                    if (out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_LCUR;
                end
            end
            S_LCUR: begin
                // Hook the first new node under the last existing one.
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = lbit ? {r_cdata[NW-1:2*AW], AW'(r_idx), r_cdata[AW-1:0]}
                               : {r_cdata[NW-1:AW], AW'(r_idx)};
                n_state = S_LNEW;
            end
            S_LNEW: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_idx);
                wr_data = lbit_n ? {r_sym, new_child, {AW{1'b0}}}
                                 : {r_sym, {AW{1'b0}}, new_child};
                n_idx   = r_idx + CW'(1);
                n_depth = r_depth + 6'd1;
                if (ld_last) begin
                    n_nu    = r_idx + CW'(1);
                    n_state = S_LDONE;
                end
            end
            S_LDONE: begin
                push = 1'b1;
                if (out_free) n_state = S_IDLE;
            end
            S_DWALK: begin
                if (landed_leaf) begin
                    // Release the previous symbol; this one waits to learn if it ends the item.
                    push   = r_pend;
                    p_sym  = r_pend_sym;
                    p_has  = 1'b1;
                    p_last = 1'b0;
                    p_done = r_pend_done;
                    if (!r_pend || out_free) begin
                        n_emitted   = r_emitted + 32'd1;
                        n_pend      = 1'b1;
                        n_pend_sym  = rd_sym;
                        n_pend_done = done_after;
                        n_wpos      = '0;
                        if (done_after || (r_left == '0)) begin
                            n_state = S_END;
                        end else if (step_miss) begin
                            n_state = S_MISS;
                        end else begin
                            rd_en    = 1'b1;
                            rd_addr  = step_c;
                            n_wpos   = step_c;
                            n_left   = r_left - 4'd1;
                            n_at_cur = 1'b0;
                        end
                    end
                end else if (!r_at_cur && (r_left == '0)) begin
                    n_state = S_END;
                end else if (step_miss) begin
                    n_wpos  = '0;
                    n_state = S_MISS;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = step_c;
                    n_wpos   = step_c;
                    n_left   = r_left - 4'd1;
                    n_at_cur = 1'b0;
                end
            end
            S_MISS: begin
                push = 1'b1;
                if (r_pend) begin
                    p_sym  = r_pend_sym;
                    p_has  = 1'b1;
                    p_last = 1'b0;
                    p_done = r_pend_done;
                    if (out_free) n_pend = 1'b0;
                end else begin
                    p_stat = ST_MISSING;
                    if (out_free) n_state = S_IDLE;
                end
            end
            S_END: begin
                push = 1'b1;
                if (r_pend) begin
                    p_sym  = r_pend_sym;
                    p_has  = 1'b1;
                    p_done = r_pend_done;
                end
                if (out_free) begin
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = r_ovalid;
        n_osym   = r_osym;
        n_ohas   = r_ohas;
        n_olast  = r_olast;
        n_odone  = r_odone;
        n_ostat  = r_ostat;
        if (out_free) begin
            n_ovalid = push;
            if (push) begin
                n_osym  = p_sym;
                n_ohas  = p_has;
                n_olast = p_last;
                n_odone = p_done;
                n_ostat = p_stat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_nu      <= '0;
            r_wpos    <= '0;
            r_emitted <= '0;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_at_cur  <= 1'b0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_nu      <= n_nu;
            r_wpos    <= n_wpos;
            r_emitted <= n_emitted;
            r_pend    <= n_pend;
            r_ovalid  <= n_ovalid;
            r_at_cur  <= n_at_cur;
            r_left    <= n_left;
        end
        r_op        <= n_op;
        r_sym       <= n_sym;
        r_len       <= n_len;
        r_bits      <= n_bits;
        r_byte      <= n_byte;
        r_cur       <= n_cur;
        r_cdata     <= n_cdata;
        r_depth     <= n_depth;
        r_idx       <= n_idx;
        r_need      <= n_need;
        r_pend_sym  <= n_pend_sym;
        r_pend_done <= n_pend_done;
        r_osym      <= n_osym;
        r_ohas      <= n_ohas;
        r_olast     <= n_olast;
        r_odone     <= n_odone;
        r_ostat     <= n_ostat;
        // Mirror every root write so a walk can restart without a read.
        if (wr_en && (wr_addr == '0)) begin
            r_root <= wr_data;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_ostat, r_odone, r_osym};
    assign m_axis_tuser  = r_ohas;
    assign m_axis_tlast  = r_olast;

endmodule

// ===== hw/rtl/htd_checker.sv =====
// Port-level checks of the Huffman tree decoder, bound to the top level.
`include "huffman_tree_decoder_top_macros.svh"

module htd_checker
    import htd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic [0:0]           m_axis_tuser,
    input  logic                 m_axis_tlast
);

    `HTD_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
    `HTD_ASSERT_RST(a_sym_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[11:9] == ST_OK, "symbol result with error status")
    `HTD_ASSERT_RST(a_err_closes, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[11:9] != ST_OK) |-> m_axis_tlast && !m_axis_tuser[0], "error result not final or carries symbol")
    `HTD_ASSERT_RST(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second transfer taken while busy")
    `HTD_ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind huffman_tree_decoder_top htd_checker u_htd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/huffman_tree_decoder_top_tb.sv =====
// Self-checking testbench for the Huffman tree decoder top level.
`timescale 1ns / 1ps

module huffman_tree_decoder_top_tb;
    import htd_pkg::*;

    localparam int TREE_DEPTH = DEF_NODE_DEPTH;

    typedef struct packed {
        logic              op;
        logic [SYM_W-1:0]  code_symbol;
        logic [LEN_W-1:0]  code_length;
        logic [BITS_W-1:0] code_bits;
        logic [BYTE_W-1:0] data_byte;
    } stream_item_t;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic              has_symbol;
        logic              last_of_item;
        logic              stream_done;
        logic [STAT_W-1:0] status;
    } decoded_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    huffman_tree_decoder_top #(
        .NODE_DEPTH(TREE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Decoder state as the testbench sees it
    int          kid0 [TREE_DEPTH];
    int          kid1 [TREE_DEPTH];
    bit [7:0]    leaf_sym [TREE_DEPTH];
    int          tree_nodes = 0;
    int          walk_node = 0;
    bit [31:0]   emitted_cnt = '0;
    bit [31:0]   target_cnt = '0;

    stream_item_t stream_q [$];
    decoded_t     decoded_q [$];

    int  mismatch_cnt = 0;
    int  results_seen = 0;
    bit  s_fire = 1'b0;
    bit  m_fire = 1'b0;

    function automatic decoded_t mk_result(input logic [7:0] sym, input logic has,
                                           input logic last, input logic [2:0] st);
        decoded_t r;
        r.symbol       = sym;
        r.has_symbol   = has;
        r.last_of_item = last;
        r.stream_done  = (emitted_cnt >= target_cnt);
        r.status       = st;
        return r;
    endfunction

    // Insert one code into the tree; all or nothing.
    function automatic logic [STAT_W-1:0] tree_load(input logic [7:0] sym,
                                                    input logic [5:0] len,
                                                    input logic [31:0] bits);
        int   need;
        int   depth;
        int   cur;
        int   nxt;
        int   j;
        logic b;
        if (len == 0 || len > MAX_CODE_LEN)
            return ST_BAD_LEN;
        need  = (tree_nodes == 0) ? 1 : 0;
        depth = 0;
        cur   = 0;
        if (tree_nodes != 0) begin
            while (depth < int'(len)) begin
                b   = bits[int'(len) - 1 - depth];
                nxt = b ? kid1[cur] : kid0[cur];
                if (nxt == 0)
                    break;
                cur = nxt;
                depth++;
            end
        end
        need += int'(len) - depth;
        if (need > TREE_DEPTH - tree_nodes)
            return ST_FULL;
        if (tree_nodes == 0) begin
            kid0[0]     = 0;
            kid1[0]     = 0;
            leaf_sym[0] = sym;
            tree_nodes  = 1;
        end
        cur = 0;
        for (j = 0; j < int'(len); j++) begin
            b   = bits[int'(len) - 1 - j];
            nxt = b ? kid1[cur] : kid0[cur];
            if (nxt == 0) begin
                nxt = tree_nodes;
                tree_nodes++;
                kid0[nxt]     = 0;
                kid1[nxt]     = 0;
                leaf_sym[nxt] = sym;
                if (b)
                    kid1[cur] = nxt;
                else
                    kid0[cur] = nxt;
            end
            cur = nxt;
        end
        return ST_OK;
    endfunction

    // Walk one byte MSB first and queue the symbols it should produce.
    function automatic void walk_byte(input logic [7:0] db);
        decoded_t          res [9];
        int                n;
        int                b;
        int                nxt;
        int                i;
        logic [STAT_W-1:0] st;
        bit                stop;
        if (emitted_cnt >= target_cnt) begin
            decoded_q.push_back(mk_result(8'h00, 1'b0, 1'b1, ST_AFTER_END));
            return;
        end
        n    = 0;
        st   = ST_OK;
        stop = 1'b0;
        for (b = 7; b >= 0; b--) begin
            if (!stop) begin
                if (kid0[walk_node] == 0) begin
                    st        = ST_MISSING;
                    walk_node = 0;
                    stop      = 1'b1;
                end else begin
                    nxt = db[b] ? kid1[walk_node] : kid0[walk_node];
                    if (nxt == 0) begin
                        st        = ST_MISSING;
                        walk_node = 0;
                        stop      = 1'b1;
                    end else begin
                        walk_node = nxt;
                        // no 0-child means leaf
                        if (kid0[nxt] == 0) begin
                            emitted_cnt++;
                            walk_node = 0;
                            res[n] = mk_result(leaf_sym[nxt], 1'b1, 1'b0, ST_OK);
                            n++;
                            if (emitted_cnt >= target_cnt)
                                stop = 1'b1;
                        end
                    end
                end
            end
        end
        if (st != ST_OK || n == 0) begin
            res[n] = mk_result(8'h00, 1'b0, 1'b1, st);
            n++;
        end else begin
            res[n-1].last_of_item = 1'b1;
        end
        for (i = 0; i < n; i++)
            decoded_q.push_back(res[i]);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= 60)
            $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Input side: predict on every transfer
    always @(posedge i_clk) begin
        s_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (s_fire) begin
            if (s_axis_tuser[0] == OP_LOAD)
                decoded_q.push_back(mk_result(8'h00, 1'b0, 1'b1,
                                              tree_load(s_axis_tdata[7:0],
                                                        s_axis_tdata[13:8],
                                                        s_axis_tdata[45:14])));
            else
                walk_byte(s_axis_tdata[53:46]);
        end
    end

    // Output side: compare against the oldest expectation
    always @(posedge i_clk) begin
        decoded_t want;
        m_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (m_fire) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
                report_mismatch("result with nothing expected, symbol",
                                int'(m_axis_tdata[7:0]), -1);
            end else begin
                want = decoded_q.pop_front();
                if (m_axis_tdata[7:0] !== want.symbol)
                    report_mismatch("symbol", int'(m_axis_tdata[7:0]), int'(want.symbol));
                if (m_axis_tuser[0] !== want.has_symbol)
                    report_mismatch("has_symbol", int'(m_axis_tuser[0]),
                                    int'(want.has_symbol));
                if (m_axis_tlast !== want.last_of_item)
                    report_mismatch("last_of_item", int'(m_axis_tlast),
                                    int'(want.last_of_item));
                if (m_axis_tdata[8] !== want.stream_done)
                    report_mismatch("stream_done", int'(m_axis_tdata[8]),
                                    int'(want.stream_done));
                if (m_axis_tdata[11:9] !== want.status)
                    report_mismatch("status", int'(m_axis_tdata[11:9]), int'(want.status));
            end
        end
    end

    // Sender: random gaps between items, with gapless bursts
    int tx_gap = 0;
    bit tx_burst = 1'b0;
    always @(negedge i_clk) begin
        stream_item_t it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_fire) begin
            // hold until the transfer completes
        end else if (tx_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            tx_gap--;
        end else if (stream_q.size() != 0) begin
            it = stream_q.pop_front();
            s_axis_tdata  <= {2'b00, it.data_byte, it.code_bits, it.code_length,
                              it.code_symbol};
            s_axis_tuser  <= it.op;
            s_axis_tvalid <= 1'b1;
            if ($urandom_range(0, 15) == 0)
                tx_burst = !tx_burst;
            tx_gap = tx_burst ? 0 : $urandom_range(0, 19);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the input
    int rx_wait = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit rx_burst = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (!hold_done && results_seen >= 300 && stream_q.size() > 4) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (m_fire) begin
                if ($urandom_range(0, 15) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic put_load(input logic [7:0] sym, input logic [5:0] len,
                            input logic [31:0] bits);
        stream_item_t it;
        it.op          = OP_LOAD;
        it.code_symbol = sym;
        it.code_length = len;
        it.code_bits   = bits;
        it.data_byte   = 8'($urandom);
        stream_q.push_back(it);
    endtask

    task automatic put_byte(input logic [7:0] db);
        stream_item_t it;
        it.op          = OP_DATA;
        it.code_symbol = 8'($urandom);
        it.code_length = 6'($urandom_range(0, 32));
        it.code_bits   = $urandom;
        it.data_byte   = db;
        stream_q.push_back(it);
    endtask

    task automatic put_rand_load();
        int         pick;
        logic [5:0] len;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = 6'd0;
        else if (pick < 4)
            len = 6'd32;
        else if (pick < 12)
            len = 6'($urandom_range(1, 8));
        else
            len = 6'($urandom_range(9, 31));
        put_load(8'($urandom), len, $urandom);
    endtask

    task automatic put_rand_byte();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            put_byte(8'h00);
        else if (pick == 1)
            put_byte(8'hFF);
        else
            put_byte(8'($urandom));
    endtask

    task automatic wait_idle();
        while (stream_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_symbol_count(input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_SYMBOL_COUNT);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        target_cnt = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        bit [31:0] cw_bits [$];
        int        cw_len [$];
        int        pick;
        int        nleaves;
        int        ph;
        int        k;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stream already over at a count of zero
        set_symbol_count(32'h0000_0000);
        put_byte(8'h5A);
        wait_idle();

        set_symbol_count(32'hFFFF_FFFF);
        put_byte(8'h00);                                // no tree yet
        put_load(8'h12, 6'd0, 32'hFFFF_FFFF);           // zero length
        put_load(8'hFF, 6'd32, 32'hFFFF_FFFF);          // longest code, all ones
        put_byte(8'hFF);                                // root is a leaf
        put_load(8'h00, 6'd1, 32'hFFFF_FFFE);           // bits above the code ignored
        put_byte(8'h00);
        put_byte(8'hFF);
        put_load(8'h5A, 6'd2, 32'h0000_0002);
        put_byte(8'h80);
        put_byte(8'hC3);
        put_load(8'h11, 6'd3, 32'h0000_0000);
        put_byte(8'h00);                                // walk crosses the byte edge
        put_byte(8'h40);
        put_byte(8'h04);
        put_byte(8'h25);
        put_load(8'h3C, 6'd32, 32'h5555_5555);
        put_byte(8'h55);
        wait_idle();

        // Count runs out inside a byte
        set_symbol_count(emitted_cnt + 32'd3);
        put_byte(8'h00);
        put_byte(8'h00);
        wait_idle();
        if (emitted_cnt != 0)
            set_symbol_count(emitted_cnt - 32'd1);
        put_byte(8'hFF);
        wait_idle();

        // Random: complete prefix code, then bytes over it
        set_symbol_count(32'hFFFF_FFFF);
        cw_bits.push_back(32'd0);
        cw_len.push_back(0);
        nleaves = $urandom_range(24, 40);
        while (cw_len.size() < nleaves) begin
            pick = $urandom_range(0, cw_len.size() - 1);
            if (cw_len[pick] < 8) begin
                cw_bits.push_back({cw_bits[pick][30:0], 1'b1});
                cw_len.push_back(cw_len[pick] + 1);
                cw_bits[pick] = cw_bits[pick] << 1;
                cw_len[pick]++;
            end
        end
        for (k = 0; k < cw_len.size(); k++)
            put_load(8'($urandom), 6'(cw_len[k]), cw_bits[k]);
        repeat (40)
            put_rand_byte();

        for (ph = 0; ph < 8; ph++) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0, 1, 2: set_symbol_count(emitted_cnt + 32'($urandom_range(1, 40)));
                3:       set_symbol_count(emitted_cnt + 32'($urandom_range(100, 400)));
                4:       set_symbol_count(32'hFFFF_FFFF);
                5:       set_symbol_count(emitted_cnt);
                default: set_symbol_count(emitted_cnt + 32'($urandom_range(40, 100)));
            endcase
            repeat (50) begin
                if ($urandom_range(0, 99) < 18)
                    put_rand_load();
                else
                    put_rand_byte();
            end
        end

        wait_idle();
        repeat (24) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("huffman_tree_decoder_top_tb: done, clean");
        else
            $display("huffman_tree_decoder_top_tb: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("huffman_tree_decoder_top_tb: done, errors");
        $finish;
    end

endmodule
